FILE: design/sha_pkg.sv
// sha_pkg: shared types and constants for the streaming sha-256 hasher
// no dependencies; imported by the top level, sha_front and sha_back
`default_nettype none
package sha_pkg;

  // queue beat between front and back: one message byte and/or end of message
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } sha_item_t;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam logic [255:0] IvWords = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] iv_word(input logic [2:0] i);
    iv_word = IvWords[(7 - 32'(i)) * 32 +: 32];
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    round_k = k;
  endfunction

endpackage
`default_nettype wire

FILE: design/sha256_stream_hasher.sv
// sha256_stream_hasher: streaming sha-256 hasher, top level
// depends on sha_pkg, sha_front and sha_back
//
// usage
//   input beats on s_*: tdata = data_byte, tuser = byte_valid, tlast = last.
//   a beat with tuser high adds one message byte; tlast ends the message.
//   beats with neither are accepted and ignored.
//   output beats on m_*: tdata = digest word, tuser = word index,
//   tlast = eighth word; eight beats per message, word 0 first.
// throughput
//   one byte per cycle into a 4-deep queue while it has room; the back end
//   loads one byte a cycle while taking bytes and runs one round a cycle on
//   the single round unit, so a 64-byte block is loaded, then compressed in
//   64 rounds, then added into the hash (feed-forward). after last, padding
//   and one or two blocks follow, then the digest is shown one word per accepted beat.
// reset
//   rst clears the queue, length and loads the initial hash values.
// stalls
//   when m_tready is low the digest holds; the queue keeps taking input
//   until it fills, then s_tready drops.
`default_nettype none
module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte
  input  wire logic        s_tuser,   // byte_valid
  input  wire logic        s_tlast,   // last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // digest_word
  output logic [2:0]       m_tuser,   // word_index
  output logic             m_tlast    // last_word
);
  import sha_pkg::*;

  sha_item_t q_item;
  logic      q_valid, q_ready;

  // input side
  sha_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .q_valid, .q_ready, .q_item
  );

  // hashing core
  sha_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );
endmodule
`default_nettype wire

FILE: design/sha_front.sv
// sha_front: input stage and item queue of the sha-256 hasher
// depends on sha_pkg; feeds sha_back through a short fifo
`default_nettype none
module sha_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,
  input  wire logic              s_tuser,
  input  wire logic              s_tlast,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output sha_pkg::sha_item_t     q_item
);
  import sha_pkg::*;

  sha_item_t             mem [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr, rd_ptr;
  logic [QueuePtrW:0]    count;
  logic                  push, pop;

  // beats carrying neither a byte nor last are dropped here
  assign s_tready = (count != (QueuePtrW+1)'(QueueDepth));
  assign push     = s_tvalid && s_tready && (s_tuser || s_tlast);
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data_byte: s_tdata, byte_valid: s_tuser, last: s_tlast};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: design/sha_back.sv
// sha_back: block buffer, padding, 64-round compression and digest output
// depends on sha_pkg; takes items from sha_front
`default_nettype none
module sha_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  sha_pkg::sha_item_t     q_item,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [31:0]            m_tdata,
  output logic [2:0]             m_tuser,
  output logic                   m_tlast
);
  import sha_pkg::*;

  localparam logic [2:0] StLoad = 3'd0;  // taking bytes
  localparam logic [2:0] StPad  = 3'd1;  // writing pad bytes
  localparam logic [2:0] StRnd  = 3'd2;  // compression rounds
  localparam logic [2:0] StOut  = 3'd3;  // digest words out

  logic [2:0]   state;
  logic [15:0][31:0] w;           // message schedule window, w[0] oldest
  logic [5:0]   fill;             // bytes in current block
  logic [60:0]  msg_bytes;
  logic         finishing;        // message end seen, padding in progress
  logic         final_blk;        // block being compressed is the last one
  logic [31:0]  hw [8];
  logic [31:0]  a, b, c, d, e, f, g, h;
  logic [5:0]   rnd;
  logic         add_pending;      // add working vars into hash after rounds
  logic [2:0]   oidx;
  logic         pad_mark;         // 0x80 still owed after a byte+last beat

  logic [63:0]  bits;
  logic [7:0]   pad_byte;
  logic [31:0]  s0, s1, wnew, t1, t2, w_t;

  assign bits = {msg_bytes, 3'b000};

  // pad byte for the current position once 0x80 is placed
  always_comb begin
    if (fill >= 6'd56 && final_blk) pad_byte = bits[(63 - 32'(fill - 6'd56) * 8) -: 8];
    else                            pad_byte = 8'h00;
  end

  assign w_t  = w[0];
  assign s0   = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
  assign s1   = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
  assign wnew = w[0] + s0 + w[9] + s1;
  assign t1   = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
              + ((e & f) ^ (~e & g)) + round_k(rnd) + w_t;
  assign t2   = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
              + ((a & b) ^ (a & c) ^ (b & c));

  assign q_ready  = (state == StLoad) && !add_pending;
  assign m_tvalid = (state == StOut);
  assign m_tdata  = hw[oidx];
  assign m_tuser  = oidx;
  assign m_tlast  = (oidx == 3'd7);

  // byte shift into the schedule window, big-endian within each word;
  // the sixteenth word stays in w[15] so that w[0] holds the first word
  function automatic logic [15:0][31:0] push_byte(input logic [7:0] bv,
                                                  input logic [5:0] pos,
                                                  input logic [15:0][31:0] win);
    logic [15:0][31:0] nw;
    nw = win;
    nw[15] = {win[15][23:0], bv};
    if (pos[1:0] == 2'd3 && pos != 6'd63) begin
      for (int i = 0; i < 15; i++) nw[i] = nw[i+1];
    end
    return nw;
  endfunction

  always_ff @(posedge clk) begin
    logic [15:0][31:0] wn;
    wn = w;
    if (rst) begin
      state       <= StLoad;
      fill        <= '0;
      msg_bytes   <= '0;
      finishing   <= 1'b0;
      final_blk   <= 1'b0;
      add_pending <= 1'b0;
      rnd         <= '0;
      oidx        <= '0;
      for (int i = 0; i < 8; i++) hw[i] <= iv_word(3'(i));
    end else begin
      case (state)
        StLoad: begin
          if (add_pending) begin
            // feed-forward after the last round
            hw[0] <= hw[0] + a; hw[1] <= hw[1] + b; hw[2] <= hw[2] + c;
            hw[3] <= hw[3] + d; hw[4] <= hw[4] + e; hw[5] <= hw[5] + f;
            hw[6] <= hw[6] + g; hw[7] <= hw[7] + h;
            add_pending <= 1'b0;
            if (finishing) begin
              if (final_blk) begin
                state <= StOut;
                oidx  <= '0;
              end else begin
                final_blk <= 1'b1;
                state     <= StPad;
              end
            end
          end else if (q_valid) begin
            if (q_item.byte_valid) begin
              wn = push_byte(q_item.data_byte, fill, wn);
              msg_bytes <= msg_bytes + 61'd1;
            end
            if (q_item.last) begin
              finishing <= 1'b1;
              state     <= StPad;
              // 0x80 goes next; decide whether length fits after it
              final_blk <= ((7'(fill) + 7'(q_item.byte_valid)) < 7'd56);
            end
            if (q_item.byte_valid) begin
              fill <= fill + 6'd1;
              if (fill == 6'd63) begin
                state <= StRnd;
                rnd   <= '0;
                a <= hw[0]; b <= hw[1]; c <= hw[2]; d <= hw[3];
                e <= hw[4]; f <= hw[5]; g <= hw[6]; h <= hw[7];
              end
            end
            if (q_item.last && !q_item.byte_valid) begin
              wn = push_byte(8'h80, fill, wn);
              fill <= fill + 6'd1;
              if (fill == 6'd63) begin
                state <= StRnd;
                rnd   <= '0;
                a <= hw[0]; b <= hw[1]; c <= hw[2]; d <= hw[3];
                e <= hw[4]; f <= hw[5]; g <= hw[6]; h <= hw[7];
              end
            end
          end
        end
        StPad: begin
          // a byte+last beat still needs its 0x80; flagged by pad_mark
          wn = push_byte(pad_mark ? 8'h80 : pad_byte, fill, wn);
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin
            state <= StRnd;
            rnd   <= '0;
            a <= hw[0]; b <= hw[1]; c <= hw[2]; d <= hw[3];
            e <= hw[4]; f <= hw[5]; g <= hw[6]; h <= hw[7];
          end
        end
        StRnd: begin
          h <= g; g <= f; f <= e; e <= d + t1;
          d <= c; c <= b; b <= a; a <= t1 + t2;
          for (int i = 0; i < 15; i++) wn[i] = w[i+1];
          wn[15] = wnew;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state       <= finishing ? StLoad : StLoad;
            add_pending <= 1'b1;
          end
        end
        StOut: begin
          if (m_tready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              state     <= StLoad;
              fill      <= '0;
              msg_bytes <= '0;
              finishing <= 1'b0;
              final_blk <= 1'b0;
              for (int i = 0; i < 8; i++) hw[i] <= iv_word(3'(i));
            end
          end
        end
        default: state <= StLoad;
      endcase
    end
    w <= wn;
  end

  // 0x80 owed: set when a last beat also carried a byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_mark <= 1'b0;
    end else if (state == StLoad && !add_pending && q_valid && q_item.last
                 && q_item.byte_valid) begin
      pad_mark <= 1'b1;
    end else if (state == StPad) begin
      pad_mark <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: design/sha_checker.sv
// sha_checker: port-level assertions for sha256_stream_hasher
// bound to the top level; depends on nothing else
`default_nettype none
module sha_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [2:0]  m_tuser,
  input wire logic        m_tlast
);
  // stalled output beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed under stall");

  // tlast marks word seven only
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == 3'd7)))
    else $error("tlast not on word seven");

  // words come out in order
  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == $past(m_tuser) + 3'd1)
    else $error("digest word order broken");
endmodule

bind sha256_stream_hasher sha_checker u_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);
`default_nettype wire
